// File: sv/bitp_pkg.sv
// ----------------------------------------------------------------------------
// bitp_pkg: shared types and constants for the MSB-first bit packer
// Command codes, field widths and the structs passed between modules.
// ----------------------------------------------------------------------------
package bitp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned OFF_W     = 32;
  localparam int unsigned FREE_W    = 4;
  localparam int unsigned MAX_BITS  = 64;
  localparam int unsigned MAX_BYTES = 8;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_WRITE_BITS = 2'd0;
  localparam cmd_t CMD_FLUSH      = 2'd1;
  localparam cmd_t CMD_APPEND     = 2'd2;

  // One output request as loaded into the output register.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [OFF_W-1:0]  byte_offset;
    logic              last;
  } out_req_t;

  // Result of one pass through the chunk merge unit.
  typedef struct packed {
    logic [BYTE_W-1:0] pending;
    logic [FREE_W-1:0] free;
    logic [FREE_W-1:0] take;
    logic              full;
  } chunk_res_t;

endpackage

// File: sv/bitp_chunk_unit.sv
// ----------------------------------------------------------------------------
// bitp_chunk_unit: shared shift-and-merge unit
// Takes up to one byte's worth of bits from the top of the remaining field
// and merges them, MSB first, into the free slots of the pending byte.
// ----------------------------------------------------------------------------
module bitp_chunk_unit (
  input  logic [bitp_pkg::DATA_W-1:0] data_i,
  input  logic [bitp_pkg::CNT_W-1:0]  rem_i,
  input  logic [bitp_pkg::BYTE_W-1:0] pending_i,
  input  logic [bitp_pkg::FREE_W-1:0] free_i,
  output bitp_pkg::chunk_res_t        res_o
);

  logic [bitp_pkg::FREE_W-1:0] take;
  logic [bitp_pkg::CNT_W-1:0]  sh;
  logic [bitp_pkg::DATA_W-1:0] shifted;
  logic [bitp_pkg::BYTE_W-1:0] mask;
  logic [bitp_pkg::BYTE_W-1:0] bits;
  logic [bitp_pkg::FREE_W-1:0] pos;

  always_comb begin
    // take as many bits as fit, capped by what is left
    take    = (rem_i < {3'b000, free_i}) ? rem_i[bitp_pkg::FREE_W-1:0] : free_i;
    sh      = rem_i - {3'b000, take};
    shifted = data_i >> sh;
    mask    = 8'hFF >> (bitp_pkg::FREE_W'(bitp_pkg::BYTE_W) - take);
    bits    = shifted[bitp_pkg::BYTE_W-1:0] & mask;
    pos     = free_i - take;
    res_o.pending = pending_i | (bits << pos);
    res_o.free    = pos;
    res_o.take    = take;
    res_o.full    = (pos == '0);
  end

endmodule

// File: sv/bitp_out_reg.sv
// ----------------------------------------------------------------------------
// bitp_out_reg: output holding register
// Holds one request until the receiver takes it; reports when a new one fits.
// ----------------------------------------------------------------------------
module bitp_out_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  bitp_pkg::out_req_t            req_i,
  output logic                          can_load_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bitp_pkg::BYTE_W-1:0]   out_byte_o,
  output logic [bitp_pkg::OFF_W-1:0]    byte_offset_o,
  output logic                          last_o
);

  logic               valid_q;
  logic               valid_d;
  bitp_pkg::out_req_t req_q;

  assign can_load_o = !valid_q || !out_stall_i;
  assign valid_d    = load_i ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      req_q <= req_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = req_q.out_byte;
  assign byte_offset_o = req_q.byte_offset;
  assign last_o        = req_q.last;

endmodule

// File: sv/msb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer: MSB-first bit-stream writer emitting a byte stream
//
// Input channel (in_valid_i / in_stall_o) carries one command per request:
// write_bits packs the low count_i bits (saturated to 64) of data_value_i,
// MSB first, into the pending byte; flush emits a partly filled byte padded
// with zeros; append_bytes flushes, then emits the low count_i bytes
// (clamped to 8) of data_value_i, least significant byte first.
// Output channel (out_valid_o / out_stall_i) carries one byte per request with
// its 32-bit wrapping stream offset; last_o marks the final byte of a command.
//
// Operation: a command is taken while idle, then a sequencer drives
// the shared chunk unit or the byte path, one step per cycle unless the
// output is stalled, for at most nine steps, where steps is the number
// of byte-sized chunks (ceil of (pending + count) / 8) for write_bits, the
// byte count plus one if bits are pending for append_bytes, and one for a
// flush with bits pending. in_stall_o is high while steps remain. A stalled
// receiver holds the output register and freezes the sequencer until the
// byte is taken. Reset clears the pending byte and the stream offset and
// leaves the block idle.
// ----------------------------------------------------------------------------
module msb_first_bit_packer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [bitp_pkg::DATA_W-1:0]   data_value_i,
  input  logic [bitp_pkg::CNT_W-1:0]    count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bitp_pkg::BYTE_W-1:0]   out_byte_o,
  output logic [bitp_pkg::OFF_W-1:0]    byte_offset_o,
  output logic                          last_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BITS  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_BYTES = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  logic [bitp_pkg::DATA_W-1:0]  data_q, data_d;
  logic [bitp_pkg::CNT_W-1:0]   rem_q, rem_d;
  logic [bitp_pkg::FREE_W-1:0]  bcnt_q, bcnt_d;
  logic                         append_q, append_d;
  logic [bitp_pkg::BYTE_W-1:0]  pend_q, pend_d;
  logic [bitp_pkg::FREE_W-1:0]  free_q, free_d;
  logic [bitp_pkg::OFF_W-1:0]   off_q, off_d;

  logic                         accept;
  logic                         can_load;
  logic                         emit;
  bitp_pkg::out_req_t           req;
  bitp_pkg::chunk_res_t         chunk;
  logic [bitp_pkg::CNT_W-1:0]   cnt_sat;
  logic [bitp_pkg::FREE_W-1:0]  bcnt_in;
  logic [bitp_pkg::CNT_W-1:0]   rem_left;
  logic                         has_pending;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign has_pending = (free_q != bitp_pkg::FREE_W'(bitp_pkg::BYTE_W));

  // Saturate the bit count and clamp the byte count.
  assign cnt_sat = (count_i > bitp_pkg::CNT_W'(bitp_pkg::MAX_BITS)) ?
                   bitp_pkg::CNT_W'(bitp_pkg::MAX_BITS) : count_i;
  assign bcnt_in = (count_i > bitp_pkg::CNT_W'(bitp_pkg::MAX_BYTES)) ?
                   bitp_pkg::FREE_W'(bitp_pkg::MAX_BYTES) :
                   count_i[bitp_pkg::FREE_W-1:0];

  bitp_chunk_unit u_chunk (
    .data_i    (data_q),
    .rem_i     (rem_q),
    .pending_i (pend_q),
    .free_i    (free_q),
    .res_o     (chunk)
  );

  assign rem_left = rem_q - {3'b000, chunk.take};

  always_comb begin
    state_d  = state_q;
    data_d   = data_q;
    rem_d    = rem_q;
    bcnt_d   = bcnt_q;
    append_d = append_q;
    pend_d   = pend_q;
    free_d   = free_q;
    off_d    = off_q;
    emit     = 1'b0;
    req.out_byte    = pend_q;
    req.byte_offset = off_q;
    req.last        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          data_d   = data_value_i;
          rem_d    = cnt_sat;
          bcnt_d   = bcnt_in;
          append_d = (command_i == bitp_pkg::CMD_APPEND);
          case (command_i)
            bitp_pkg::CMD_WRITE_BITS: begin
              if (cnt_sat != '0) state_d = ST_BITS;
            end
            bitp_pkg::CMD_FLUSH: begin
              if (has_pending) state_d = ST_FLUSH;
            end
            bitp_pkg::CMD_APPEND: begin
              if (has_pending)          state_d = ST_FLUSH;
              else if (bcnt_in != '0)   state_d = ST_BYTES;
            end
            default: ;  // unused code: drop
          endcase
        end
      end
      ST_BITS: begin
        if (can_load) begin
          rem_d = rem_left;
          if (chunk.full) begin
            // byte complete: emit it and start an empty one
            emit   = 1'b1;
            req.out_byte = chunk.pending;
            // a later byte needs eight more bits
            req.last = (rem_left < bitp_pkg::CNT_W'(bitp_pkg::BYTE_W));
            pend_d = '0;
            free_d = bitp_pkg::FREE_W'(bitp_pkg::BYTE_W);
          end else begin
            pend_d = chunk.pending;
            free_d = chunk.free;
          end
          if (rem_left == '0) state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (can_load) begin
          emit     = 1'b1;
          req.out_byte = pend_q;
          req.last = !(append_q && (bcnt_q != '0));
          pend_d   = '0;
          free_d   = bitp_pkg::FREE_W'(bitp_pkg::BYTE_W);
          state_d  = (append_q && (bcnt_q != '0)) ? ST_BYTES : ST_IDLE;
        end
      end
      ST_BYTES: begin
        if (can_load) begin
          emit     = 1'b1;
          req.out_byte = data_q[bitp_pkg::BYTE_W-1:0];
          req.last = (bcnt_q == bitp_pkg::FREE_W'(1));
          data_d   = data_q >> bitp_pkg::BYTE_W;
          bcnt_d   = bcnt_q - bitp_pkg::FREE_W'(1);
          if (bcnt_q == bitp_pkg::FREE_W'(1)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // advance the stream offset on every emitted byte
    if (emit) off_d = off_q + bitp_pkg::OFF_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= '0;
      free_q  <= bitp_pkg::FREE_W'(bitp_pkg::BYTE_W);
      off_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      free_q  <= free_d;
      off_q   <= off_d;
    end
  end

  // Operand registers: only meaningful while a command is in progress.
  always_ff @(posedge clk_i) begin
    data_q   <= data_d;
    rem_q    <= rem_d;
    bcnt_q   <= bcnt_d;
    append_q <= append_d;
  end

  bitp_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (emit),
    .req_i         (req),
    .can_load_o    (can_load),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_offset_o (byte_offset_o),
    .last_o        (last_o)
  );

endmodule

// File: sv/bitp_checker.sv
// ----------------------------------------------------------------------------
// bitp_checker: port-level assertions for the MSB-first bit packer
// Watches the channels and the running byte offset; bound to the top level.
// ----------------------------------------------------------------------------
module bitp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [1:0]                    command_i,
  input logic [bitp_pkg::CNT_W-1:0]    count_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [bitp_pkg::BYTE_W-1:0]   out_byte_o,
  input logic [bitp_pkg::OFF_W-1:0]    byte_offset_o,
  input logic                          last_o
);

  logic                       seen_q;
  logic [bitp_pkg::OFF_W-1:0] prev_q;
  logic                       out_take;
  logic                       in_take;

  assign out_take = out_valid_o && !out_stall_i;
  assign in_take  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      prev_q <= '0;
    end else if (out_take) begin
      seen_q <= 1'b1;
      prev_q <= byte_offset_o;
    end
  end

  // Hold a stalled output request.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(byte_offset_o) && $stable(last_o))
    else $error("stalled output request changed");

  // Offsets of taken bytes advance by one.
  a_offset_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && seen_q |-> byte_offset_o == prev_q + bitp_pkg::OFF_W'(1))
    else $error("byte offset did not advance by one");

  // A write_bits request with bits to pack keeps the block busy next cycle.
  a_busy_after_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && command_i == bitp_pkg::CMD_WRITE_BITS && count_i != '0
      |=> in_stall_o)
    else $error("block not busy after write_bits request");

  // Nothing is shown on the output right after reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind msb_first_bit_packer bitp_checker u_bitp_checker (.*);
